// ===== rtl/core/sabc_pkg.sv =====
// Shared types and constants for the set-associative block cache controller.
package sabc_pkg;

	localparam int SETS_DEF       = 64;
	localparam int WAYS_DEF       = 4;
	localparam int STAMP_BITS_DEF = 32;

	localparam int TAG_W      = 32;
	localparam int SET_IDX_W  = 6;
	localparam int WAY_IDX_W  = 2;
	localparam int WAY_MAX_W  = 4;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t             command;
		logic [TAG_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic [SET_IDX_W-1:0] set_index;
		logic [WAY_IDX_W-1:0] way;
		logic                 flush_needed;
		logic [TAG_W-1:0]     flush_block;
		logic                 fill_needed;
	} rsp_t;

	// Lookup outcome for one set row
	typedef struct packed {
		logic                 hit;
		logic [WAY_MAX_W-1:0] way;
		logic                 victim_valid;
		logic [TAG_W-1:0]     victim_tag;
	} pick_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_RED,
		ST_LOOK
	} state_t;

endpackage

// ===== rtl/core/sabc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sabc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, hold data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/sabc_way_pick.sv =====
// Way compare and least-recently-stamped victim selection over one set row.
module sabc_way_pick #(
	parameter int WAYS       = 4,
	parameter int STAMP_BITS = 32
) (
	input  logic [WAYS*sabc_pkg::TAG_W-1:0]  tags_row,
	input  logic [WAYS*(STAMP_BITS+1)-1:0]   meta_row,
	input  logic [sabc_pkg::TAG_W-1:0]       block_number,
	output sabc_pkg::pick_t                  pick
);
	import sabc_pkg::*;

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int P     = 1 << WAY_W;
	localparam int MW    = STAMP_BITS + 1;

	logic [STAMP_BITS-1:0] stp [0:WAY_W][0:P-1];
	logic [WAY_W-1:0]      idx [0:WAY_W][0:P-1];
	logic                  hit;
	logic [WAY_W-1:0]      hit_way;
	logic [WAY_W-1:0]      victim;

	// compare all valid ways, lowest index wins
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (meta_row[w*MW + STAMP_BITS] && tags_row[w*TAG_W +: TAG_W] == block_number) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// reduce stamps by a min tree, left side wins ties
	always_comb begin
		for (int l = 0; l <= WAY_W; l++) begin
			for (int i = 0; i < P; i++) begin
				stp[l][i] = '1;
				idx[l][i] = '0;
			end
		end
		for (int i = 0; i < P; i++) begin
			if (i < WAYS) begin
				stp[0][i] = meta_row[i*MW +: STAMP_BITS];
			end
			idx[0][i] = WAY_W'(i);
		end
		for (int l = 0; l < WAY_W; l++) begin
			for (int i = 0; i < (P >> (l + 1)); i++) begin
				if (stp[l][2*i+1] < stp[l][2*i]) begin
					stp[l+1][i] = stp[l][2*i+1];
					idx[l+1][i] = idx[l][2*i+1];
				end else begin
					stp[l+1][i] = stp[l][2*i];
					idx[l+1][i] = idx[l][2*i];
				end
			end
		end
		victim = idx[WAY_W][0];
	end

	// pack outcome
	always_comb begin
		pick.hit          = hit;
		pick.way          = WAY_MAX_W'(hit ? hit_way : victim);
		pick.victim_valid = meta_row[victim*MW + STAMP_BITS];
		pick.victim_tag   = tags_row[victim*TAG_W +: TAG_W];
	end

endmodule

// ===== rtl/core/set_assoc_block_cache_lru.sv =====
// Tag and LRU replacement controller for a set-associative block cache. Each request word
// (read or write command plus block number) gets exactly one response word: hit, set, way,
// write-back of a valid victim and fill for read misses. Tags live in one RAM row per set,
// valid bits and access stamps in a second RAM row per set. When SETS is a power of two the
// set row is read as a request is accepted in ST_IDLE, then ST_LOOK compares, picks a victim
// and writes the row back; otherwise ST_MUL and ST_RED come between, reducing the block
// number by a reciprocal multiply, and ST_RED reads the set row. A response waiting on a
// stalled output holds up the next item only once it is ready to finish. After reset a
// clearing pass over every set zeroes valid bits and stamps; requests stall until it ends.
module set_assoc_block_cache_lru #(
	parameter int SETS       = sabc_pkg::SETS_DEF,
	parameter int WAYS       = sabc_pkg::WAYS_DEF,
	parameter int STAMP_BITS = sabc_pkg::STAMP_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sabc_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sabc_pkg::rsp_t  rsp
);
	import sabc_pkg::*;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MW    = STAMP_BITS + 1;
	localparam int RW    = SET_W + 1;
	localparam bit POW2  = (SETS & (SETS - 1)) == 0;
	localparam logic [TAG_W-1:0] SET_MASK = TAG_W'(SETS - 1);
	localparam logic [TAG_W-1:0] RECIP    = TAG_W'((64'd1 << 32) / SETS);

	state_t state_q, state_d;

	logic [SET_W-1:0]       clr_q;
	cmd_t                   cmd_q;
	logic [TAG_W-1:0]       blk_q;
	logic [SET_W-1:0]       set_q;
	logic [2*TAG_W-1:0]     prod_s1;
	logic [STAMP_BITS-1:0]  cnt_q;
	logic [STAMP_BITS-1:0]  cnt_next;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic                   accept;
	logic                   can_emit;
	logic                   load_rsp;
	logic [SET_W-1:0]       set_in;
	logic [SET_W-1:0]       set_red;
	logic [TAG_W-1:0]       q_est;
	logic [RW-1:0]          qs;
	logic [RW-1:0]          diff;
	logic [RW-1:0]          red;

	logic                   rd_en;
	logic [SET_W-1:0]       rd_addr;
	logic                   meta_we;
	logic [SET_W-1:0]       meta_waddr;
	logic [WAYS*MW-1:0]     meta_wdata;
	logic [WAYS*MW-1:0]     meta_rd;
	logic                   tag_we;
	logic [WAYS*TAG_W-1:0]  tag_wdata;
	logic [WAYS*TAG_W-1:0]  tag_rd;
	logic [WAY_W-1:0]       way_sel;
	pick_t                  pick;

	assign accept   = req_valid && !req_stall;
	assign can_emit = !rsp_valid_q || !rsp_stall;
	assign cnt_next = cnt_q + STAMP_BITS'(1);
	assign set_in   = SET_W'(req.block_number & SET_MASK);

	// reduce block number modulo SETS: estimate quotient, one correction step
	assign q_est   = prod_s1[2*TAG_W-1:TAG_W];
	assign qs      = RW'(q_est[RW-1:0] * RW'(SETS));
	assign diff    = blk_q[RW-1:0] - qs;
	assign red     = (diff >= RW'(SETS)) ? diff - RW'(SETS) : diff;
	assign set_red = red[SET_W-1:0];

	// set rows: tags, and valid plus stamp
	sabc_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(SETS)) u_tag_ram (
		.clk     (clk),
		.wr_en   (tag_we),
		.wr_addr (set_q),
		.wr_data (tag_wdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (tag_rd)
	);

	sabc_ram #(.WIDTH(WAYS*MW), .DEPTH(SETS)) u_meta_ram (
		.clk     (clk),
		.wr_en   (meta_we),
		.wr_addr (meta_waddr),
		.wr_data (meta_wdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (meta_rd)
	);

	sabc_way_pick #(.WAYS(WAYS), .STAMP_BITS(STAMP_BITS)) u_pick (
		.tags_row     (tag_rd),
		.meta_row     (meta_rd),
		.block_number (blk_q),
		.pick         (pick)
	);

	assign way_sel = pick.way[WAY_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == SET_W'(SETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = POW2 ? ST_LOOK : ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_RED;
			ST_RED:  state_d = ST_LOOK;
			ST_LOOK: begin
				if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory control and row update
	always_comb begin
		req_stall  = 1'b1;
		rd_en      = 1'b0;
		rd_addr    = set_in;
		meta_we    = 1'b0;
		meta_waddr = set_q;
		meta_wdata = meta_rd;
		tag_we     = 1'b0;
		tag_wdata  = tag_rd;
		load_rsp   = 1'b0;
		meta_wdata[way_sel*MW +: MW]       = {1'b1, cnt_next};
		tag_wdata[way_sel*TAG_W +: TAG_W]  = blk_q;
		unique case (state_q)
			ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
				meta_wdata = '0;
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				rd_en     = accept && POW2;
			end
			ST_MUL: begin
			end
			ST_RED: begin
				rd_en   = 1'b1;
				rd_addr = set_red;
			end
			ST_LOOK: begin
				load_rsp = can_emit;
				meta_we  = can_emit;
				tag_we   = can_emit && !pick.hit;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (load_rsp) begin
				cnt_q       <= cnt_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture, set reduction and response word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			blk_q <= req.block_number;
			set_q <= set_in;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= blk_q * RECIP;
		end
		if (state_q == ST_RED) begin
			set_q <= set_red;
		end
		if (load_rsp) begin
			rsp_q.hit          <= pick.hit;
			rsp_q.set_index    <= SET_IDX_W'(set_q);
			rsp_q.way          <= WAY_IDX_W'(way_sel);
			rsp_q.flush_needed <= !pick.hit && pick.victim_valid;
			rsp_q.flush_block  <= (!pick.hit && pick.victim_valid) ? pick.victim_tag : '0;
			rsp_q.fill_needed  <= !pick.hit && cmd_q == CMD_READ;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
